[src/cds_pkg.sv]
// Shared types, codes and the digit table for the countdown display sequencer.
// No dependencies; every other file in src imports this package.
`default_nettype none
package cds_pkg;

   // Sequencer phases, reported on the result channel as phase.
   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_DEBOUNCE = 3'd1,
      MODE_COUNT    = 3'd2,
      MODE_FADE     = 3'd3,
      MODE_HOLD     = 3'd4,
      MODE_WAIT     = 3'd5
   } mode_type;

   // Configuration register indexes.
   localparam logic [2:0] REG_DEBOUNCE_TICKS  = 3'd0;
   localparam logic [2:0] REG_TICKS_PER_DIGIT = 3'd1;
   localparam logic [2:0] REG_START_DIGIT     = 3'd2;
   localparam logic [2:0] REG_PWM_PERIOD      = 3'd3;
   localparam logic [2:0] REG_FADE_STEPS      = 3'd4;
   localparam logic [2:0] REG_HOLD_TICKS      = 3'd5;

   localparam logic [7:0]  DEBOUNCE_RESET  = 8'd20;
   localparam logic [15:0] PER_DIGIT_RESET = 16'd1000;
   localparam logic [3:0]  START_RESET     = 4'd9;
   localparam logic [7:0]  PERIOD_RESET    = 8'd20;
   localparam logic [7:0]  STEPS_RESET     = 8'd100;
   localparam logic [15:0] HOLD_RESET      = 16'd5000;

   localparam logic [3:0] LAST_DIGIT = 4'd9;

   // Configuration values seen by the datapath.
   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] ticks_per_digit;
      logic [3:0]  start_digit;
      logic [7:0]  pwm_period;
      logic [7:0]  fade_steps;
      logic [15:0] hold_ticks;
   } cds_cfg_type;

   // Commands from the controller, valid for one accepted beat.
   typedef struct packed {
      logic tick_clr;
      logic tick_inc;
      logic load_digit;
      logic dec_digit;
      logic fade_init;
      logic pos_inc;
      logic period_next;
      logic led_set;
      logic led_clr;
   } cds_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic deb_done;
      logic digit_done;
      logic hold_done;
      logic digit_zero;
      logic period_done;
      logic fade_done;
   } cds_stat_type;

   // Segment pattern for a decimal digit, bit 0 is segment a.
   function automatic logic [6:0] digit_pattern(input logic [3:0] digit);
      logic [6:0] pat;
      unique case (digit)
         4'd0: pat = 7'h3F;
         4'd1: pat = 7'h06;
         4'd2: pat = 7'h5B;
         4'd3: pat = 7'h4F;
         4'd4: pat = 7'h66;
         4'd5: pat = 7'h6D;
         4'd6: pat = 7'h7D;
         4'd7: pat = 7'h07;
         4'd8: pat = 7'h7F;
         default: pat = 7'h6F;
      endcase
      return pat;
   endfunction

endpackage
`default_nettype wire

[src/cds_ctrl.sv]
// Phase state machine of the countdown display sequencer.
// Depends on cds_pkg; drives the datapath commands from its status.
`default_nettype none
module cds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  button,
   input  cds_pkg::cds_stat_type stat,
   output cds_pkg::cds_cmd_type  cmd,
   output cds_pkg::mode_type     mode
);
   import cds_pkg::*;

   mode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      mode_in = mode_ff;
      cmd     = '0;
      if (step) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (button) begin
                  mode_in      = MODE_DEBOUNCE;
                  cmd.tick_clr = 1'b1;
               end
            end
            MODE_DEBOUNCE: begin
               if (stat.deb_done) begin
                  cmd.tick_clr = 1'b1;
                  if (button) begin
                     cmd.load_digit = 1'b1;
                     mode_in        = MODE_COUNT;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end else begin
                  cmd.tick_inc = 1'b1;
               end
            end
            MODE_COUNT: begin
               if (stat.digit_done) begin
                  cmd.tick_clr = 1'b1;
                  if (stat.digit_zero) begin
                     cmd.fade_init = 1'b1;
                     mode_in       = MODE_FADE;
                  end else begin
                     cmd.dec_digit = 1'b1;
                  end
               end else begin
                  cmd.tick_inc = 1'b1;
               end
            end
            MODE_FADE: begin
               if (stat.period_done) begin
                  if (stat.fade_done) begin
                     cmd.fade_init = 1'b1;
                     cmd.tick_clr  = 1'b1;
                     cmd.led_set   = 1'b1;
                     mode_in       = MODE_HOLD;
                  end else begin
                     cmd.period_next = 1'b1;
                  end
               end else begin
                  cmd.pos_inc = 1'b1;
               end
            end
            MODE_HOLD: begin
               if (stat.hold_done) begin
                  cmd.tick_clr = 1'b1;
                  cmd.led_clr  = 1'b1;
                  mode_in      = MODE_WAIT;
               end else begin
                  cmd.tick_inc = 1'b1;
               end
            end
            MODE_WAIT: begin
               if (!button) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   assign mode = mode_ff;

endmodule
`default_nettype wire

[src/cds_dp.sv]
// Counters, digit register and incremental fade compare of the sequencer.
// Depends on cds_pkg; acts only on commands from cds_ctrl.
`default_nettype none
module cds_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  cds_pkg::cds_cfg_type  cfg,
   input  cds_pkg::cds_cmd_type  cmd,
   input  logic                  in_fade,
   output cds_pkg::cds_stat_type stat,
   output logic [6:0]            segments,
   output logic                  led
);
   import cds_pkg::*;

   logic [15:0] tick_ff, tick_in;
   logic [3:0]  digit_ff, digit_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  pos_ff, pos_in;
   // on_acc holds pwm_period * fade_index, thr_acc holds (pwm_position + 1) * fade_steps.
   logic [15:0] on_acc_ff, on_acc_in;
   logic [15:0] thr_acc_ff, thr_acc_in;
   logic [6:0]  pattern_ff, pattern_in;
   logic        led_ff, led_in;

   logic [16:0] tick_next;
   logic [8:0]  pos_next;
   logic [8:0]  idx_next;
   logic [3:0]  start_clamped;

   assign tick_next     = {1'b0, tick_ff} + 17'd1;
   assign pos_next      = {1'b0, pos_ff} + 9'd1;
   assign idx_next      = {1'b0, idx_ff} + 9'd1;
   assign start_clamped = (cfg.start_digit > LAST_DIGIT) ? LAST_DIGIT : cfg.start_digit;

   always_comb begin
      stat.deb_done    = tick_next >= {9'd0, cfg.debounce_ticks};
      stat.digit_done  = tick_next >= {1'b0, cfg.ticks_per_digit};
      stat.hold_done   = tick_next >= {1'b0, cfg.hold_ticks};
      stat.digit_zero  = digit_ff == 4'd0;
      stat.period_done = pos_next >= {1'b0, cfg.pwm_period};
      stat.fade_done   = idx_next >= {1'b0, cfg.fade_steps};
   end

   always_comb begin
      tick_in    = tick_ff;
      digit_in   = digit_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      on_acc_in  = on_acc_ff;
      thr_acc_in = thr_acc_ff;
      pattern_in = pattern_ff;
      led_in     = led_ff;
      if (cmd.tick_clr) begin
         tick_in = '0;
      end else if (cmd.tick_inc) begin
         tick_in = tick_next[15:0];
      end
      if (cmd.load_digit) begin
         digit_in   = start_clamped;
         pattern_in = digit_pattern(start_clamped);
      end else if (cmd.dec_digit) begin
         digit_in   = digit_ff - 4'd1;
         pattern_in = digit_pattern(digit_ff - 4'd1);
      end
      if (cmd.fade_init) begin
         idx_in     = '0;
         pos_in     = '0;
         on_acc_in  = '0;
         thr_acc_in = {8'd0, cfg.fade_steps};
      end else if (cmd.period_next) begin
         idx_in     = idx_next[7:0];
         pos_in     = '0;
         on_acc_in  = on_acc_ff + {8'd0, cfg.pwm_period};
         thr_acc_in = {8'd0, cfg.fade_steps};
      end else if (cmd.pos_inc) begin
         pos_in     = pos_next[7:0];
         thr_acc_in = thr_acc_ff + {8'd0, cfg.fade_steps};
      end
      if (cmd.led_set) begin
         led_in = 1'b1;
      end else if (cmd.led_clr) begin
         led_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         digit_ff   <= '0;
         idx_ff     <= '0;
         pos_ff     <= '0;
         on_acc_ff  <= '0;
         thr_acc_ff <= '0;
         pattern_ff <= '0;
         led_ff     <= 1'b0;
      end else begin
         tick_ff    <= tick_in;
         digit_ff   <= digit_in;
         idx_ff     <= idx_in;
         pos_ff     <= pos_in;
         on_acc_ff  <= on_acc_in;
         thr_acc_ff <= thr_acc_in;
         pattern_ff <= pattern_in;
         led_ff     <= led_in;
      end
   end

   // During the fade the LED is on while pwm_position < floor(period * index / steps),
   // which is the same as (pwm_position + 1) * steps <= period * index.
   assign segments = pattern_ff;
   assign led      = in_fade ? ((cfg.fade_steps != 8'd0) && (thr_acc_ff <= on_acc_ff))
                             : led_ff;

endmodule
`default_nettype wire

[src/countdown_display_sequencer.sv]
// Top level of the countdown display sequencer: configuration registers,
// result register and the controller/datapath pair. Depends on cds_pkg,
// cds_ctrl and cds_dp.
//
//   channel  direction  beat contents (low bit first)
//   req_     in         tdata: button
//   rsp_     out        tdata: segments[6:0], led, phase[2:0], zero pad
//   csr_     in         write enable, register index, write data
//
// Each request beat is one millisecond tick; it produces exactly one
// response beat that shows the state before the tick, then the state moves on.
// A beat is taken every cycle while the response register is empty or being
// drained, so the sustained rate is one tick per clock, set by the single
// response register. Reset brings the sequencer to idle with the display blank,
// the LED off and all registers at their documented defaults. A stalled
// response holds its beat and blocks further requests until it is taken.
`default_nettype none
module countdown_display_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] segments, [7] led, [10:8] phase, [15:11] zero
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import cds_pkg::*;

   cds_cfg_type  cfg_ff, cfg_in;
   cds_cmd_type  cmd;
   cds_stat_type stat;
   mode_type     mode;
   logic [6:0]   segments;
   logic         led;
   logic         step;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [15:0]  rsp_data_ff, rsp_data_in;

   // Configuration writes land directly; an index outside the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE_TICKS:  cfg_in.debounce_ticks  = csr_wdata[7:0];
            REG_TICKS_PER_DIGIT: cfg_in.ticks_per_digit = csr_wdata;
            REG_START_DIGIT:     cfg_in.start_digit     = csr_wdata[3:0];
            REG_PWM_PERIOD:      cfg_in.pwm_period      = csr_wdata[7:0];
            REG_FADE_STEPS:      cfg_in.fade_steps      = csr_wdata[7:0];
            REG_HOLD_TICKS:      cfg_in.hold_ticks      = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks  <= DEBOUNCE_RESET;
         cfg_ff.ticks_per_digit <= PER_DIGIT_RESET;
         cfg_ff.start_digit     <= START_RESET;
         cfg_ff.pwm_period      <= PERIOD_RESET;
         cfg_ff.fade_steps      <= STEPS_RESET;
         cfg_ff.hold_ticks      <= HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A tick is accepted whenever the response register can take its beat.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   cds_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .button (req_tdata[0]),
      .stat   (stat),
      .cmd    (cmd),
      .mode   (mode)
   );

   cds_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .cmd      (cmd),
      .in_fade  (mode == MODE_FADE),
      .stat     (stat),
      .segments (segments),
      .led      (led)
   );

   // The response captures the outputs as they stood before this tick.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, mode, led, segments};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // The LED is fully on for every beat of the hold phase.
   a_hold_led_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[10:8] == MODE_HOLD)) |-> rsp_data_ff[7])
      else $error("LED off during hold phase");

   // The LED is dark in idle and while waiting for release.
   a_idle_led_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_data_ff[10:8] == MODE_IDLE) ||
                        (rsp_data_ff[10:8] == MODE_WAIT))) |-> !rsp_data_ff[7])
      else $error("LED on in idle or wait release");

   // A failed recheck of the button drops the sequencer back to idle.
   a_debounce_abort: assert property (@(posedge clock) disable iff (reset)
      (step && (mode == MODE_DEBOUNCE) && stat.deb_done && !req_tdata[0])
      |=> (mode == MODE_IDLE))
      else $error("debounce abort did not return to idle");

   // Requests are held off only while a response beat is pending.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff)
      else $error("request stalled with empty response register");
`endif

endmodule
`default_nettype wire

[tb/countdown_display_sequencer_test.sv]
// Self-checking testbench for the countdown display sequencer: one tick beat in,
// one display beat out, predicted by a cycle-free model of the tick sequencer.
// Depends on cds_pkg and countdown_display_sequencer from the src folder.
module countdown_display_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cds_pkg::*;

   // Roughly how many tick beats the directed and random parts queue in total.
   localparam int unsigned TICK_BUDGET = 1300;
   // A correct run never goes this long without a beat on either channel. The
   // longest quiet stretch is the drain and register writes between settings,
   // plus a short run of random stalls.
   localparam int unsigned QUIET_LIMIT = 1000;
   localparam int unsigned MAX_REPORTS = 10;

   // Segment patterns for the digits 0 to 9, bit 0 is segment a.
   localparam logic [6:0] SEGMENT_FONT [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // Everything the sequencer remembers from one tick to the next.
   typedef struct packed {
      mode_type    mode;
      logic [15:0] tick_count;
      logic [3:0]  digit;
      logic [7:0]  fade_index;
      logic [7:0]  pwm_position;
      logic [6:0]  pattern;
      logic        led_level;
   } sequencer_state_type;

   // One display beat, laid out as the low bits of rsp_tdata.
   typedef struct packed {
      logic [2:0] phase;
      logic       led;
      logic [6:0] segments;
   } tick_view_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [0] button, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [6:0] segments, [7] led, [10:8] phase, [15:11] zero
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   // Register values the predictor works with; they change only while the
   // block has nothing in flight.
   cds_cfg_type         sequencer_cfg;
   // The state that follows the accepted beats, and the state that follows
   // every queued beat; the second one steers the stimulus.
   sequencer_state_type model_state;
   sequencer_state_type plan_state;

   logic                pending_buttons [$];
   tick_view_type       expected_views [$];
   tick_view_type       predicted_view;
   tick_view_type       observed_view;
   tick_view_type       wanted_view;

   int unsigned ticks_queued;
   int unsigned req_beats_offered;
   int unsigned req_beats_in;
   int unsigned rsp_beats_in;
   int unsigned error_count;
   int unsigned quiet_cycles;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;

   countdown_display_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Applies one tick to a sequencer state. The view shows the state as it
   // was at the start of the tick; the button then moves the state on.
   function automatic void advance_tick(inout sequencer_state_type st, input logic pressed,
                                        output tick_view_type view);
      logic [15:0] product;
      logic [15:0] on_ticks;
      view.segments = st.pattern;
      view.phase    = st.mode;
      if (st.mode == MODE_FADE) begin
         // The LED is on for the first period*step/steps ticks of each period.
         // With no fade steps configured it stays dark.
         product = {8'd0, sequencer_cfg.pwm_period} * {8'd0, st.fade_index};
         if (sequencer_cfg.fade_steps == 8'd0) begin
            on_ticks = 16'd0;
         end else begin
            on_ticks = product / {8'd0, sequencer_cfg.fade_steps};
         end
         view.led = ({8'd0, st.pwm_position} < on_ticks);
      end else begin
         view.led = st.led_level;
      end

      // A zero in any timing register ends its wait after one tick, since the
      // counter is bumped before it is compared.
      case (st.mode)
         MODE_IDLE: begin
            if (pressed) begin
               st.mode       = MODE_DEBOUNCE;
               st.tick_count = 16'd0;
            end
         end
         MODE_DEBOUNCE: begin
            st.tick_count = st.tick_count + 16'd1;
            if (st.tick_count >= {8'd0, sequencer_cfg.debounce_ticks}) begin
               st.tick_count = 16'd0;
               // The last debounce tick decides: still pressed starts the
               // countdown, released drops back to idle.
               if (pressed) begin
                  st.digit   = (sequencer_cfg.start_digit > 4'd9) ? 4'd9
                                                                  : sequencer_cfg.start_digit;
                  st.pattern = SEGMENT_FONT[st.digit];
                  st.mode    = MODE_COUNT;
               end else begin
                  st.mode = MODE_IDLE;
               end
            end
         end
         MODE_COUNT: begin
            st.tick_count = st.tick_count + 16'd1;
            if (st.tick_count >= sequencer_cfg.ticks_per_digit) begin
               st.tick_count = 16'd0;
               if (st.digit == 4'd0) begin
                  // Zero stays on the display through the fade and beyond.
                  st.mode         = MODE_FADE;
                  st.fade_index   = 8'd0;
                  st.pwm_position = 8'd0;
               end else begin
                  st.digit   = st.digit - 4'd1;
                  st.pattern = SEGMENT_FONT[st.digit];
               end
            end
         end
         MODE_FADE: begin
            st.pwm_position = st.pwm_position + 8'd1;
            if (st.pwm_position >= sequencer_cfg.pwm_period) begin
               st.pwm_position = 8'd0;
               st.fade_index   = st.fade_index + 8'd1;
               if (st.fade_index >= sequencer_cfg.fade_steps) begin
                  st.fade_index = 8'd0;
                  st.mode       = MODE_HOLD;
                  st.tick_count = 16'd0;
                  st.led_level  = 1'b1;
               end
            end
         end
         MODE_HOLD: begin
            st.tick_count = st.tick_count + 16'd1;
            if (st.tick_count >= sequencer_cfg.hold_ticks) begin
               st.tick_count = 16'd0;
               st.led_level  = 1'b0;
               st.mode       = MODE_WAIT;
            end
         end
         default: begin
            // Waiting for release: only a low button returns to idle.
            if (!pressed) st.mode = MODE_IDLE;
         end
      endcase
   endfunction

   task automatic report_error(input string what, input tick_view_type want,
                               input tick_view_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display({"display beat %0d: %s; expected seg %h led %b phase %0d, ",
                   "got seg %h led %b phase %0d"},
                  rsp_beats_in, what, want.segments, want.led, want.phase,
                  got.segments, got.led, got.phase);
      end
   endtask

   // Driver. Request and response ready both change on the falling edge. A
   // request beat is held until the rising edge that takes it; only then is a
   // new beat or an idle cycle chosen, so req_tvalid gets one update per edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beats_in == req_beats_offered) begin
         if (pending_buttons.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_tdata  <= {7'd0, pending_buttons.pop_front()};
            req_tvalid <= 1'b1;
            req_beats_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor. On each rising edge the accepted tick beat is predicted first,
   // then the accepted display beat is checked against the oldest prediction,
   // so a beat that went straight through would still find its expectation.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_tick(model_state, req_tdata[0], predicted_view);
            expected_views.push_back(predicted_view);
            req_beats_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            observed_view = rsp_tdata[10:0];
            if (expected_views.size() == 0) begin
               report_error("display beat with no tick waiting", observed_view,
                            observed_view);
            end else begin
               wanted_view = expected_views.pop_front();
               if (observed_view.segments !== wanted_view.segments) begin
                  report_error("segments differ", wanted_view, observed_view);
               end else if (observed_view.led !== wanted_view.led) begin
                  report_error("led differs", wanted_view, observed_view);
               end else if (observed_view.phase !== wanted_view.phase) begin
                  report_error("phase differs", wanted_view, observed_view);
               end
            end
            rsp_beats_in++;
         end
         // Watchdog: a block that stops taking or giving beats ends the run.
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL countdown_display_sequencer");
            $finish;
         end
      end
   end

   // Queues one tick beat and moves the planning state along with it, so the
   // next choice of button knows which phase the block will be in.
   task automatic queue_tick(input logic pressed);
      tick_view_type ignored;
      advance_tick(plan_state, pressed, ignored);
      pending_buttons.push_back(pressed);
      ticks_queued++;
   endtask

   // Queues at least min_ticks beats of button activity and stops once the
   // sequencer is back in idle. Most sequences are pressed through the
   // debounce and released in the wait phase; drop_pct of the debounce ticks
   // see a release, which breaks a sequence when it lands on the recheck.
   task automatic queue_button_activity(input int unsigned min_ticks,
                                        input int unsigned drop_pct);
      int unsigned count;
      logic        pressed;
      count = 0;
      while (count < min_ticks || plan_state.mode != MODE_IDLE) begin
         case (plan_state.mode)
            MODE_IDLE:     pressed = ($urandom_range(99) < 60);
            MODE_DEBOUNCE: pressed = ($urandom_range(99) >= drop_pct);
            MODE_WAIT:     pressed = ($urandom_range(99) < 40);
            default:       pressed = 1'($urandom_range(1));
         endcase
         queue_tick(pressed);
         count++;
      end
   endtask

   // Waits on falling edges until every queued tick was taken and every
   // display beat has come back. Each tick gives exactly one beat, so nothing
   // is left in flight after that.
   task automatic wait_for_drain();
      while (req_beats_in != ticks_queued || expected_views.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
   endtask

   // Writes all six registers, one per cycle. The new values only matter to
   // the predictor once tick beats flow again.
   task automatic apply_settings(input cds_cfg_type settings);
      write_register(REG_DEBOUNCE_TICKS,  {8'd0, settings.debounce_ticks});
      write_register(REG_TICKS_PER_DIGIT, settings.ticks_per_digit);
      write_register(REG_START_DIGIT,     {12'd0, settings.start_digit});
      write_register(REG_PWM_PERIOD,      {8'd0, settings.pwm_period});
      write_register(REG_FADE_STEPS,      {8'd0, settings.fade_steps});
      write_register(REG_HOLD_TICKS,      settings.hold_ticks);
      @(negedge clock);
      csr_we <= 1'b0;
      sequencer_cfg = settings;
   endtask

   initial begin
      cds_cfg_type settings;
      int unsigned setting_index;

      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = 8'd0;
      rsp_tready        = 1'b0;
      csr_we            = 1'b0;
      csr_index         = REG_DEBOUNCE_TICKS;
      csr_wdata         = 16'd0;
      ticks_queued      = 0;
      req_beats_offered = 0;
      req_beats_in      = 0;
      rsp_beats_in      = 0;
      error_count       = 0;
      quiet_cycles      = 0;
      sender_idle_pct   = 28;
      receiver_idle_pct = 46;
      sequencer_cfg     = '{DEBOUNCE_RESET, PER_DIGIT_RESET, START_RESET,
                            PERIOD_RESET, STEPS_RESET, HOLD_RESET};
      model_state       = '0;
      model_state.mode  = MODE_IDLE;
      plan_state        = model_state;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Right after reset the display is blank, the LED dark and the phase idle.
      queue_tick(1'b0);
      queue_tick(1'b0);
      wait_for_drain();

      // Directed sequence with tiny timings: a press that is released before
      // the recheck, then one full pass through every phase, where the fade
      // runs two steps of three ticks, and a release that comes one tick late.
      apply_settings('{8'd1, 16'd1, 4'd1, 8'd3, 8'd2, 16'd1});
      queue_tick(1'b1); queue_tick(1'b0);
      queue_tick(1'b1); queue_tick(1'b1);
      queue_tick(1'b0); queue_tick(1'b1);
      queue_tick(1'b1); queue_tick(1'b0); queue_tick(1'b1);
      queue_tick(1'b0); queue_tick(1'b1); queue_tick(1'b0);
      queue_tick(1'b1);
      queue_tick(1'b1); queue_tick(1'b0);
      queue_tick(1'b0);
      wait_for_drain();

      // Random part. The first settings cover the corner cases: zero in every
      // timing register with a start digit above nine, a long debounce with a
      // wide single-step fade, and a fade of many one-tick periods. The rest
      // are small random settings so that many full sequences fit.
      setting_index = 0;
      while (ticks_queued < TICK_BUDGET) begin
         case (setting_index)
            0: settings = '{8'd0, 16'd0, 4'd15, 8'd0, 8'd0, 16'd0};
            1: settings = '{8'd255, 16'd2, 4'd9, 8'd255, 8'd1, 16'd3};
            2: settings = '{8'd3, 16'd1, 4'd10, 8'd1, 8'd255, 16'd2};
            default: begin
               settings.debounce_ticks  = 8'($urandom_range(0, 4));
               settings.ticks_per_digit = 16'($urandom_range(0, 3));
               settings.start_digit     = 4'($urandom_range(0, 15));
               settings.pwm_period      = 8'($urandom_range(0, 6));
               settings.fade_steps      = 8'($urandom_range(0, 7));
               settings.hold_ticks      = 16'($urandom_range(0, 5));
            end
         endcase
         // Stall pattern: receiver idles more than sender first, then the
         // other way round, then both run flat out.
         if (ticks_queued < 450) begin
            sender_idle_pct   = 28;
            receiver_idle_pct = 46;
         end else if (ticks_queued < 900) begin
            sender_idle_pct   = 46;
            receiver_idle_pct = 28;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         apply_settings(settings);
         queue_button_activity($urandom_range(30, 90), 15);
         wait_for_drain();
         setting_index++;
      end

      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_views.size() == 0) begin
         $display("PASS countdown_display_sequencer");
      end else begin
         $display("FAIL countdown_display_sequencer");
      end
      $finish;
   end

endmodule

[files.f]
src/cds_pkg.sv
src/cds_ctrl.sv
src/cds_dp.sv
src/countdown_display_sequencer.sv
tb/countdown_display_sequencer_test.sv
